// ===== sv/rfc_pkg.sv =====
package rfc_pkg;

  localparam int HEADER_BYTES = 4;
  localparam int CHECK_BYTES  = 2;
  localparam int MAX_PAYLOAD  = 128;
  localparam int MIN_PACKET   = HEADER_BYTES + CHECK_BYTES;
  localparam int MAX_PACKET   = HEADER_BYTES + MAX_PAYLOAD + CHECK_BYTES;

  localparam int COUNT_W = 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [1:0] POS_MAGIC  = 2'd0;
  localparam logic [1:0] POS_LENGTH = 2'd1;
  localparam logic [1:0] POS_MSG_ID = 2'd2;
  localparam logic [1:0] POS_SEQ    = 2'd3;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_SIZE   = 3'd1,
    ST_BAD_MAGIC  = 3'd2,
    ST_BAD_LENGTH = 3'd3,
    ST_BAD_CRC    = 3'd4
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  localparam int OUT_DATA_W = 40;

  // CRC-16/MCRF4XX update over one byte, bit-reflected.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/radio_frame_checker.sv =====
// Channel  | Signals                            | Contents
// ---------+------------------------------------+------------------------------------------
// input    | s_axis_tvalid/tready/tdata/tlast   | one packet byte, tlast on the final byte
// output   | m_axis_tvalid/tready/tdata/tuser   | payload byte or packet status
// config   | cfg_we, cfg_wdata                  | expected magic byte
//
// Each request is processed combinationally and its result, if any, appears in the
// output register on the next cycle. One byte is accepted every cycle as long as the
// output register is empty or being drained in the same cycle. The CRC update is a
// byte-wide unrolled step that feeds the running CRC register.
// Synchronous reset clears the packet state, the magic register and the output valid.
// An output stall holds the result and blocks input only while it persists.
module radio_frame_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // [7:0] rx_byte
  input  logic                                s_axis_tlast,  // end_of_packet
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] payload_byte, [10:8] status, [18:11] message_id,
  // [26:19] sequence_res, [34:27] payload_length, [39:35] zero
  output logic [rfc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tuser,  // kind
  input  logic                                cfg_we,
  input  logic [7:0]                          cfg_wdata      // magic_value
);

  logic [7:0]                   magic_value;
  logic [rfc_pkg::COUNT_W-1:0]  byte_count, byte_count_next;
  logic [15:0]                  running_crc, running_crc_next;
  logic [7:0]                   header_magic, header_magic_next;
  logic [7:0]                   header_length, header_length_next;
  logic [7:0]                   header_msg_id, header_msg_id_next;
  logic [7:0]                   header_seq, header_seq_next;
  logic [7:0]                   received_crc, received_crc_next;
  logic [15:0]                  frozen_crc, frozen_crc_next;

  logic [rfc_pkg::COUNT_W-1:0]  crc_end;
  logic [rfc_pkg::COUNT_W-1:0]  total;
  logic [15:0]                  crc_upd;
  logic [15:0]                  rx_crc;
  logic                         emit_payload;
  logic                         produce;
  logic                         s_fire;
  rfc_pkg::status_t             status_next;
  logic [rfc_pkg::OUT_DATA_W-1:0] data_next;
  rfc_pkg::kind_t               kind_next;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign crc_end = rfc_pkg::COUNT_W'(rfc_pkg::HEADER_BYTES) + {1'b0, header_length};
  assign crc_upd = rfc_pkg::crc_byte(running_crc, s_axis_tdata);

  always_comb begin
    byte_count_next    = byte_count;
    running_crc_next   = running_crc;
    header_magic_next  = header_magic;
    header_length_next = header_length;
    header_msg_id_next = header_msg_id;
    header_seq_next    = header_seq;
    received_crc_next  = received_crc;
    frozen_crc_next    = frozen_crc;
    emit_payload       = 1'b0;

    if (byte_count < rfc_pkg::COUNT_W'(rfc_pkg::HEADER_BYTES)) begin
      case (byte_count[1:0])
        rfc_pkg::POS_MAGIC:  header_magic_next  = s_axis_tdata;
        rfc_pkg::POS_LENGTH: header_length_next = s_axis_tdata;
        rfc_pkg::POS_MSG_ID: header_msg_id_next = s_axis_tdata;
        rfc_pkg::POS_SEQ:    header_seq_next    = s_axis_tdata;
        default:             header_seq_next    = header_seq;
      endcase
      running_crc_next = crc_upd;
    end else if (byte_count < crc_end) begin
      running_crc_next = crc_upd;
      emit_payload     = header_length <= 8'(rfc_pkg::MAX_PAYLOAD);
    end else if (byte_count == crc_end) begin
      frozen_crc_next   = running_crc;
      received_crc_next = s_axis_tdata;
    end

    total  = (byte_count == rfc_pkg::COUNT_MAX) ? byte_count : byte_count + 1'b1;
    rx_crc = {s_axis_tdata, received_crc_next};

    if (total < rfc_pkg::COUNT_W'(rfc_pkg::MIN_PACKET) ||
        total > rfc_pkg::COUNT_W'(rfc_pkg::MAX_PACKET)) begin
      status_next = rfc_pkg::ST_BAD_SIZE;
    end else if (header_magic_next != magic_value) begin
      status_next = rfc_pkg::ST_BAD_MAGIC;
    end else if (header_length_next > 8'(rfc_pkg::MAX_PAYLOAD) ||
                 total != rfc_pkg::COUNT_W'(rfc_pkg::MIN_PACKET) +
                          {1'b0, header_length_next}) begin
      status_next = rfc_pkg::ST_BAD_LENGTH;
    end else if (rx_crc != frozen_crc_next) begin
      status_next = rfc_pkg::ST_BAD_CRC;
    end else begin
      status_next = rfc_pkg::ST_OK;
    end

    if (s_axis_tlast) begin
      kind_next = rfc_pkg::KIND_STATUS;
      data_next = {5'd0, header_length_next, header_seq_next, header_msg_id_next,
                   status_next, 8'd0};
      produce   = 1'b1;
    end else begin
      kind_next = rfc_pkg::KIND_PAYLOAD;
      data_next = {5'd0, header_length_next, header_seq_next, header_msg_id_next,
                   rfc_pkg::ST_OK, s_axis_tdata};
      produce   = emit_payload;
      if (byte_count != rfc_pkg::COUNT_MAX) begin
        byte_count_next = byte_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_value <= '0;
    end else if (cfg_we) begin
      magic_value <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      running_crc   <= rfc_pkg::CRC_INIT;
      header_magic  <= '0;
      header_length <= '0;
      header_msg_id <= '0;
      header_seq    <= '0;
      received_crc  <= '0;
      frozen_crc    <= '0;
    end else if (s_fire) begin
      if (s_axis_tlast) begin
        byte_count    <= '0;
        running_crc   <= rfc_pkg::CRC_INIT;
        header_magic  <= '0;
        header_length <= '0;
        header_msg_id <= '0;
        header_seq    <= '0;
        received_crc  <= '0;
        frozen_crc    <= '0;
      end else begin
        byte_count    <= byte_count_next;
        running_crc   <= running_crc_next;
        header_magic  <= header_magic_next;
        header_length <= header_length_next;
        header_msg_id <= header_msg_id_next;
        header_seq    <= header_seq_next;
        received_crc  <= received_crc_next;
        frozen_crc    <= frozen_crc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_fire && produce) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && produce) begin
      m_axis_tdata <= data_next;
      m_axis_tuser <= kind_next;
    end
  end

endmodule

// ===== sv/rfc_checker.sv =====
module rfc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [7:0]                     s_axis_tdata,
  input logic                           s_axis_tlast,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rfc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           cfg_we,
  input logic [7:0]                     cfg_wdata
);

  logic unused_in;
  assign unused_in = s_axis_tvalid ^ s_axis_tlast ^ cfg_we ^ (^s_axis_tdata) ^ (^cfg_wdata);

  a_hold: assert property (@(posedge clk) disable iff (rst || unused_in === 1'bx)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Output request dropped while stalled.");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("Input stalled while the output register is empty.");

  a_status_zero_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
    else $error("Status result carries a nonzero payload byte.");

  a_payload_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[10:8] == rfc_pkg::ST_OK)
    else $error("Payload result carries a nonzero status.");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[10:8] <= rfc_pkg::ST_BAD_CRC &&
                      m_axis_tdata[rfc_pkg::OUT_DATA_W-1:35] == '0)
    else $error("Result holds an undefined status or nonzero padding.");

endmodule

bind radio_frame_checker rfc_checker u_rfc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_we        (cfg_we),
  .cfg_wdata     (cfg_wdata)
);

// ===== tb/radio_frame_checker_test.sv =====
`timescale 1ns / 1ps

module radio_frame_checker_test;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    rfc_pkg::kind_t   kind;
    logic [7:0]       payload;
    rfc_pkg::status_t status;
    logic [7:0]       msg_id;
    logic [7:0]       seq_no;
    logic [7:0]       length;
  } frame_result_t;

  class packet_tracker;
    logic [7:0]    magic;
    logic [8:0]    byte_cnt;
    logic [15:0]   crc;
    logic [7:0]    hdr_magic;
    logic [7:0]    hdr_len;
    logic [7:0]    hdr_id;
    logic [7:0]    hdr_seq;
    logic [7:0]    crc_lo;
    logic [15:0]   crc_frozen;
    int unsigned   errors;
    frame_result_t expected_results[$];

    function new();
      magic = 8'h00;
      errors = 0;
      clear();
    endfunction

    function void clear();
      byte_cnt = '0;
      crc = rfc_pkg::CRC_INIT;
      hdr_magic = '0;
      hdr_len = '0;
      hdr_id = '0;
      hdr_seq = '0;
      crc_lo = '0;
      crc_frozen = '0;
    endfunction

    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] d);
      logic fb;
      for (int k = 0; k < 8; k++) begin
        fb = c[0] ^ d[k];
        c = {1'b0, c[15:1]};
        if (fb) begin
          c = c ^ rfc_pkg::CRC_POLY;
        end
      end
      return c;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void absorb_byte(logic [7:0] b, logic last);
      logic [8:0]    pos;
      logic [8:0]    crc_end;
      bit            emit;
      int unsigned   n;
      logic [15:0]   rx_crc;
      frame_result_t r;
      pos = byte_cnt;
      crc_end = 9'(rfc_pkg::HEADER_BYTES) + {1'b0, hdr_len};
      emit = 0;
      if (pos < rfc_pkg::HEADER_BYTES) begin
        case (pos[1:0])
          rfc_pkg::POS_MAGIC:  hdr_magic = b;
          rfc_pkg::POS_LENGTH: hdr_len = b;
          rfc_pkg::POS_MSG_ID: hdr_id = b;
          default:             hdr_seq = b;
        endcase
        crc = crc_step(crc, b);
      end else if (pos < crc_end) begin
        crc = crc_step(crc, b);
        emit = (hdr_len <= rfc_pkg::MAX_PAYLOAD);
      end else if (pos == crc_end) begin
        crc_frozen = crc;
        crc_lo = b;
      end
      r.msg_id = hdr_id;
      r.seq_no = hdr_seq;
      r.length = hdr_len;
      if (last) begin
        n = pos + 1;
        if (n > rfc_pkg::COUNT_MAX) begin
          n = rfc_pkg::COUNT_MAX;
        end
        rx_crc = {b, crc_lo};
        if (n < rfc_pkg::MIN_PACKET || n > rfc_pkg::MAX_PACKET) begin
          r.status = rfc_pkg::ST_BAD_SIZE;
        end else if (hdr_magic != magic) begin
          r.status = rfc_pkg::ST_BAD_MAGIC;
        end else if (hdr_len > rfc_pkg::MAX_PAYLOAD ||
                     n != rfc_pkg::MIN_PACKET + hdr_len) begin
          r.status = rfc_pkg::ST_BAD_LENGTH;
        end else if (rx_crc != crc_frozen) begin
          r.status = rfc_pkg::ST_BAD_CRC;
        end else begin
          r.status = rfc_pkg::ST_OK;
        end
        r.kind = rfc_pkg::KIND_STATUS;
        r.payload = '0;
        expected_results.push_back(r);
        clear();
        return;
      end
      if (byte_cnt != rfc_pkg::COUNT_MAX) begin
        byte_cnt = byte_cnt + 1'b1;
      end
      if (emit) begin
        r.kind = rfc_pkg::KIND_PAYLOAD;
        r.payload = b;
        r.status = rfc_pkg::ST_OK;
        expected_results.push_back(r);
      end
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void compare_output(logic kind_bit, logic [rfc_pkg::OUT_DATA_W-1:0] d);
      frame_result_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: result without a pending request, expected none, actual kind %0d data %h",
                 $time, kind_bit, d);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      check_field("kind", int'(e.kind), kind_bit);
      check_field("payload_byte", e.payload, d[7:0]);
      check_field("status", int'(e.status), d[10:8]);
      check_field("message_id", e.msg_id, d[18:11]);
      check_field("sequence", e.seq_no, d[26:19]);
      check_field("payload_length", e.length, d[34:27]);
      check_field("padding", 0, d[rfc_pkg::OUT_DATA_W-1:35]);
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata = '0;
  logic                           s_axis_tlast = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [rfc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           cfg_we = 1'b0;
  logic [7:0]                     cfg_wdata = '0;

  packet_tracker sb;
  logic [7:0]    pkt[$];
  bit            calm = 1'b0;
  int unsigned   cycles = 0;
  int unsigned   sent = 0;

  radio_frame_checker dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // A result leaves before the request of the same edge is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.compare_output(m_axis_tuser, m_axis_tdata);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.absorb_byte(s_axis_tdata, s_axis_tlast);
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else begin
        m_axis_tready = 1'b1;
        if (!calm) begin
          stall = gap_len();
        end
      end
    end
  end

  task automatic push_byte(logic [7:0] b, logic last);
    int g;
    g = calm ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    s_axis_tlast = last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_magic(logic [7:0] v);
    drain();
    repeat (3) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.magic = v;
  endtask

  task automatic make_packet(logic [7:0] m, int len_field, int payload_n, bit bad_crc);
    logic [15:0] c;
    pkt = {};
    pkt.push_back(m);
    pkt.push_back(8'(len_field));
    pkt.push_back(8'($urandom));
    pkt.push_back(8'($urandom));
    repeat (payload_n) pkt.push_back(8'($urandom));
    c = rfc_pkg::CRC_INIT;
    foreach (pkt[i]) c = packet_tracker::crc_step(c, pkt[i]);
    if (bad_crc) begin
      c = c ^ (16'h1 << $urandom_range(0, 15));
    end
    pkt.push_back(c[7:0]);
    pkt.push_back(c[15:8]);
  endtask

  task automatic send_packet(int hold_at);
    foreach (pkt[i]) begin
      if (i == hold_at) begin
        drain();
      end
      push_byte(pkt[i], i == pkt.size() - 1);
    end
  endtask

  task automatic random_packet();
    int          r;
    int          len;
    int          hold;
    logic [7:0]  m;
    r = $urandom_range(0, 99);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, rfc_pkg::MAX_PAYLOAD)
                                      : $urandom_range(0, 12);
    if (r < 55) begin
      make_packet(sb.magic, len, len, $urandom_range(0, 99) < 15);
    end else if (r < 63) begin
      m = sb.magic ^ 8'($urandom_range(1, 255));
      make_packet(m, len, len, 1'b0);
    end else if (r < 73) begin
      make_packet(sb.magic, len, len, 1'b0);
      if ($urandom_range(0, 1) == 0) begin
        pkt = pkt[0:$urandom_range(0, pkt.size() - 2)];
      end else begin
        repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
      end
    end else if (r < 81) begin
      make_packet(sb.magic, $urandom_range(rfc_pkg::MAX_PAYLOAD + 1, 255),
                  $urandom_range(0, 10), 1'b0);
    end else if (r < 91) begin
      pkt = {};
      repeat ($urandom_range(1, 5)) pkt.push_back(8'($urandom));
      if ($urandom_range(0, 1) == 0) begin
        pkt[0] = sb.magic;
      end
    end else begin
      pkt = {};
      repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
    end
    hold = -1;
    if (pkt.size() > 1 && $urandom_range(0, 19) == 0) begin
      hold = $urandom_range(1, pkt.size() - 1);
    end
    calm = ($urandom_range(0, 4) == 0);
    send_packet(hold);
    calm = 1'b0;
  endtask

  initial begin
    logic [7:0] magics[4];
    int         phase_start;
    sb = new();
    repeat (6) @(negedge clk);
    rst = 1'b0;

    make_packet(8'h00, 0, 0, 1'b0);
    send_packet(-1);
    pkt = {8'hFF};
    send_packet(-1);
    make_packet(8'h5A, 0, 0, 1'b0);
    send_packet(-1);
    make_packet(8'h00, 1, 1, 1'b1);
    send_packet(-1);
    make_packet(8'h00, 5, 5, 1'b0);
    pkt = pkt[0:6];
    send_packet(-1);

    magics[0] = 8'hFF;
    magics[1] = 8'($urandom);
    magics[2] = 8'h00;
    magics[3] = 8'($urandom);
    for (int p = 0; p < 4; p++) begin
      set_magic(magics[p]);
      if (p == 0) begin
        make_packet(sb.magic, rfc_pkg::MAX_PAYLOAD, rfc_pkg::MAX_PAYLOAD, 1'b0);
        send_packet(-1);
      end
      if (p == 2) begin
        // The count saturates, so this long packet must read as bad size.
        make_packet(sb.magic, 16, 16, 1'b0);
        repeat (500) pkt.push_back(8'($urandom));
        send_packet(-1);
      end
      phase_start = sent;
      while (sent - phase_start < 35) random_packet();
    end

    drain();
    repeat (5) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
